>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

>>> src/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Types and constants shared by the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 3 * PIX_W;
    localparam int COEFF_W = 6;
    localparam int KERN_W  = 54;
    localparam int DIV_W   = 10;
    localparam int SUM_W   = 18;
    localparam int PROD_W  = PIX_W + COEFF_W;
    localparam int TAP_W   = 4;
    localparam int CNT_W   = 5;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 64;

    localparam logic [KERN_W-1:0] KERNEL_RESET  = 54'd285942833483841;
    localparam logic [DIV_W-1:0]  DIVISOR_RESET = 10'd9;

    localparam logic [TAP_W-1:0] LAST_TAP      = 4'd8;
    localparam logic [CNT_W-1:0] LAST_DIV_STEP = 5'd17;

    // register index, taken from paddr[3]
    localparam logic REG_KERNEL  = 1'b0;
    localparam logic REG_DIVISOR = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] above_pix;
        logic [PIX_W-1:0] centre_pix;
        logic [PIX_W-1:0] below_pix;
        logic             row_start;
        logic             row_end;
    } t_col_item;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pix;
        logic             row_last;
    } t_res_item;

    typedef struct packed {
        logic             load;
        logic             load_end;
        logic             clr_acc;
        logic             mac;
        logic [TAP_W-1:0] tap;
        logic             div_init;
        logic             div_step;
        logic             push;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_mid;
        logic pend_end;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/c3f_if.sv
// ----------------------------------------------------------------------------
// c3f_if
// Valid/ready channels for pixel columns in and filtered pixels out.
// ----------------------------------------------------------------------------
interface c3f_col_if;
    import c3f_pkg::*;

    logic      valid;
    logic      ready;
    t_col_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c3f_res_if;
    import c3f_pkg::*;

    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/c3f_dp.sv
// ----------------------------------------------------------------------------
// c3f_dp
// Column window, multiply-accumulate, restoring divider and output register.
// ----------------------------------------------------------------------------
module c3f_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  c3f_pkg::t_col_item           i_col,
    input  c3f_pkg::t_dp_cmd             i_cmd,
    input  logic [c3f_pkg::KERN_W-1:0]   i_kernel_coeffs,
    input  logic [c3f_pkg::DIV_W-1:0]    i_divisor,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output c3f_pkg::t_res_item           o_res,
    output c3f_pkg::t_dp_status          o_status
);
    import c3f_pkg::*;

    logic [COL_W-1:0]   r_left;
    logic [COL_W-1:0]   r_mid;
    logic               r_mid_vld;
    logic               r_pend_mid;
    logic               r_pend_end;
    logic               r_out_valid;

    logic [COL_W-1:0]   r_win [3];
    logic               r_last;
    logic [SUM_W-1:0]   r_acc;
    logic [DIV_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_quo;
    t_res_item          r_res;

    logic [COL_W-1:0]   w_col;
    logic               w_eff_vld;
    logic [1:0]         w_tap_row;
    logic [1:0]         w_tap_col;
    logic [COL_W-1:0]   w_sel_col;
    logic [PIX_W-1:0]   w_pix;
    logic [COEFF_W-1:0] w_coeff;
    logic [PROD_W-1:0]  w_prod;
    logic [DIV_W:0]     w_trial;
    logic [DIV_W:0]     w_diff;
    logic               w_ge;

    assign w_col     = {i_col.above_pix, i_col.centre_pix, i_col.below_pix};
    assign w_eff_vld = r_mid_vld && !i_col.row_start;

    always_comb begin
        case (i_cmd.tap)
            4'd0, 4'd1, 4'd2: w_tap_row = 2'd0;
            4'd3, 4'd4, 4'd5: w_tap_row = 2'd1;
            default:          w_tap_row = 2'd2;
        endcase
        case (i_cmd.tap)
            4'd0, 4'd3, 4'd6: w_tap_col = 2'd0;
            4'd1, 4'd4, 4'd7: w_tap_col = 2'd1;
            default:          w_tap_col = 2'd2;
        endcase
    end

    always_comb begin
        case (w_tap_col)
            2'd0:    w_sel_col = r_win[0];
            2'd1:    w_sel_col = r_win[1];
            default: w_sel_col = r_win[2];
        endcase
        case (w_tap_row)
            2'd0:    w_pix = w_sel_col[3*PIX_W-1:2*PIX_W];
            2'd1:    w_pix = w_sel_col[2*PIX_W-1:PIX_W];
            default: w_pix = w_sel_col[PIX_W-1:0];
        endcase
    end

    assign w_coeff = i_kernel_coeffs[i_cmd.tap*COEFF_W +: COEFF_W];
    assign w_prod  = PROD_W'(w_pix) * PROD_W'(w_coeff);

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_mid       <= '0;
            r_mid_vld   <= 1'b0;
            r_pend_mid  <= 1'b0;
            r_pend_end  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend_mid <= w_eff_vld;
                r_pend_end <= i_col.row_end;
                r_left     <= w_eff_vld ? r_mid : '0;
                r_mid      <= w_col;
                r_mid_vld  <= 1'b1;
            end
            if (i_cmd.load_end) begin
                r_pend_end <= 1'b0;
                r_left     <= '0;
                r_mid      <= '0;
                r_mid_vld  <= 1'b0;
            end
            if (i_cmd.push) begin
                r_pend_mid  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[0] <= r_left;
            r_win[1] <= r_mid;
            r_win[2] <= w_col;
            r_last   <= 1'b0;
        end else if (i_cmd.load_end) begin
            r_win[0] <= r_left;
            r_win[1] <= r_mid;
            r_win[2] <= '0;
            r_last   <= 1'b1;
        end
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + SUM_W'(w_prod);
        end
        if (i_cmd.div_init) begin
            r_quo <= r_acc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        end
        if (i_cmd.push) begin
            r_res.filtered_pix <= r_quo[PIX_W-1:0];
            r_res.row_last     <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_res             = r_res;
    assign o_status.pend_mid = r_pend_mid;
    assign o_status.pend_end = r_pend_end;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

>>> src/c3f_ctrl.sv
// ----------------------------------------------------------------------------
// c3f_ctrl
// Sequencer: takes a column, then runs MAC and divide for each result.
// ----------------------------------------------------------------------------
module c3f_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  c3f_pkg::t_dp_status i_status,
    output c3f_pkg::t_dp_cmd    o_cmd
);
    import c3f_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEL,
        S_MAC,
        S_DIVI,
        S_DIV,
        S_PUSH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_job;

    assign w_job = i_status.pend_mid || i_status.pend_end;

    always_comb begin
        o_cmd      = '0;
        o_cmd.tap  = r_cnt[TAP_W-1:0];
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SEL: begin
                o_cmd.load_end = !i_status.pend_mid && i_status.pend_end;
                o_cmd.clr_acc  = w_job;
            end
            S_MAC:   o_cmd.mac      = 1'b1;
            S_DIVI:  o_cmd.div_init = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_PUSH:  o_cmd.push     = i_status.out_free;
            default: o_cmd          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_cnt   <= '0;
                    r_state <= w_job ? S_MAC : S_IDLE;
                end
                S_MAC: begin
                    if (r_cnt[TAP_W-1:0] == LAST_TAP) begin
                        r_state <= S_DIVI;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIVI: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == LAST_DIV_STEP) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (i_status.out_free) begin
                        r_state <= S_SEL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/conv3x3_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_filter
// 3x3 convolution of an 8-bit plane, one pixel column per item, with
// configurable kernel and truncating divisor.
//
//   channel  | dir | handshake      | payload
//   i_col    | in  | valid / ready  | above, centre, below pixel, row flags
//   o_res    | out | valid / ready  | filtered pixel, last-of-row flag
//   APB      | in  | psel / penable | kernel coeffs (0x0), divisor (0x8)
//
// Each result runs 9 MAC taps on the shared multiplier, 18 restoring
// divide steps on the one-bit-per-cycle divider and the SEL, DIVI and
// PUSH control states; an item yields 0, 1 or 2 results.
// Synchronous active-low reset; kernel resets to a box blur, divisor to 9.
// A stalled output holds its item; the next column is taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module conv3x3_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    c3f_col_if.sink                       i_col,
    c3f_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c3f_pkg::APB_AW-1:0]    paddr,
    input  logic [c3f_pkg::APB_DW-1:0]    pwdata,
    output logic [c3f_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import c3f_pkg::*;

    logic [KERN_W-1:0] r_kernel;
    logic [DIV_W-1:0]  r_divisor;
    logic              w_wr;
    t_dp_cmd           w_cmd;
    t_dp_status        w_status;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= KERNEL_RESET;
            r_divisor <= DIVISOR_RESET;
        end else if (w_wr) begin
            if (paddr[3] == REG_KERNEL) begin
                r_kernel <= pwdata[KERN_W-1:0];
            end else begin
                r_divisor <= pwdata[DIV_W-1:0];
            end
        end
    end

    assign prdata = (paddr[3] == REG_DIVISOR) ? APB_DW'(r_divisor) : APB_DW'(r_kernel);

    c3f_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_col.valid),
        .o_in_ready (i_col.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    c3f_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_col           (i_col.data),
        .i_cmd           (w_cmd),
        .i_kernel_coeffs (r_kernel),
        .i_divisor       (r_divisor),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_res           (o_res.data),
        .o_status        (w_status)
    );

    `ASSERT_CLK(a_push_room, i_clk, i_rst_n, w_cmd.push |-> (!o_res.valid || o_res.ready), "result pushed over a held item")
    `ASSERT_CLK(a_busy_after_take, i_clk, i_rst_n, (i_col.valid && i_col.ready) |=> !i_col.ready, "column taken while busy")
    `ASSERT_CLK(a_cmd_excl, i_clk, i_rst_n, $onehot0({w_cmd.load, w_cmd.load_end, w_cmd.mac, w_cmd.div_init, w_cmd.div_step, w_cmd.push}), "datapath commands overlap")
    `ASSERT_CLK(a_end_clears, i_clk, i_rst_n, w_cmd.load_end |=> !w_status.pend_end, "row end result not retired")

endmodule
